// File: design/wfpd_pkg.sv
// Package for the wall-following PD steering block.
// Holds register widths, reset values, register indexes, maneuver codes and the config bundle.
// Used by every module in the design folder; it depends on nothing.
package wfpd_pkg;

   localparam int SAMPLES_PER_AVERAGE_DEFAULT = 5;
   localparam int SAMPLE_BITS_DEFAULT         = 10;

   localparam int LEVEL_BITS  = 10;
   localparam int SPEED_BITS  = 7;
   localparam int GAIN_BITS   = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam int ERR_BITS     = 11;
   localparam int DELTA_BITS   = ERR_BITS + 1;
   localparam int KP_TERM_BITS = GAIN_BITS + 1 + ERR_BITS;
   localparam int KD_TERM_BITS = GAIN_BITS + 1 + DELTA_BITS;
   localparam int Q_BITS       = KD_TERM_BITS + 2;
   localparam int DRIVE_BITS   = 8;
   localparam int MAN_BITS     = 2;
   localparam int RSP_DATA_BITS = 32;

   localparam int ERR_LIMIT   = 1023;
   localparam int SPEED_LIMIT = 127;
   localparam int VEER_LEFT   = 30;
   localparam int VEER_RIGHT  = 32;

   localparam logic [LEVEL_BITS-1:0] SIDE_SETPOINT_RESET    = 10'd550;
   localparam logic [LEVEL_BITS-1:0] FRONT_WALL_LEVEL_RESET = 10'd550;
   localparam logic [LEVEL_BITS-1:0] SIDE_WALL_LEVEL_RESET  = 10'd550;
   localparam logic [LEVEL_BITS-1:0] SIDE_OPEN_LEVEL_RESET  = 10'd100;
   localparam logic [SPEED_BITS-1:0] BASE_SPEED_RESET       = 7'd30;
   localparam logic [GAIN_BITS-1:0]  KP_GAIN_RESET          = 16'd8;
   localparam logic [GAIN_BITS-1:0]  KD_GAIN_RESET          = 16'd333;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_SIDE_SETPOINT    = 3'd0,
      CSR_FRONT_WALL_LEVEL = 3'd1,
      CSR_SIDE_WALL_LEVEL  = 3'd2,
      CSR_SIDE_OPEN_LEVEL  = 3'd3,
      CSR_BASE_SPEED       = 3'd4,
      CSR_KP_GAIN          = 3'd5,
      CSR_KD_GAIN          = 3'd6
   } csr_index_type;

   localparam logic [MAN_BITS-1:0] MAN_NONE       = 2'd0;
   localparam logic [MAN_BITS-1:0] MAN_TURN_RIGHT = 2'd1;
   localparam logic [MAN_BITS-1:0] MAN_TURN_LEFT  = 2'd2;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] side_setpoint;
      logic [LEVEL_BITS-1:0] front_wall_level;
      logic [LEVEL_BITS-1:0] side_wall_level;
      logic [LEVEL_BITS-1:0] side_open_level;
      logic [SPEED_BITS-1:0] base_speed;
      logic [GAIN_BITS-1:0]  kp_gain_q8;
      logic [GAIN_BITS-1:0]  kd_gain_q8;
   } cfg_type;

endpackage

// File: design/wfpd_accum.sv
// Sample accumulator: sums front/left/right triples and hands off run totals.
// Depends on wfpd_pkg for nothing but the house constants; totals leave through a register.
module wfpd_accum #(
   parameter int SAMPLES_PER_AVERAGE = wfpd_pkg::SAMPLES_PER_AVERAGE_DEFAULT,
   parameter int SAMPLE_BITS         = wfpd_pkg::SAMPLE_BITS_DEFAULT,
   localparam int SUM_BITS           = SAMPLE_BITS + $clog2(SAMPLES_PER_AVERAGE)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] front_sample,
   input  logic [SAMPLE_BITS-1:0] left_sample,
   input  logic [SAMPLE_BITS-1:0] right_sample,
   output logic                   run_last,
   output logic                   tot_valid,
   input  logic                   tot_ready,
   output logic [SUM_BITS-1:0]    tot_front,
   output logic [SUM_BITS-1:0]    tot_left,
   output logic [SUM_BITS-1:0]    tot_right
);

   localparam int CNT_BITS = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [SUM_BITS-1:0] front_sum_ff, left_sum_ff, right_sum_ff;
   logic [SUM_BITS-1:0] front_sum_in, left_sum_in, right_sum_in;
   logic [SUM_BITS-1:0] front_tot_in, left_tot_in, right_tot_in;
   logic [SUM_BITS-1:0] front_tot_ff, left_tot_ff, right_tot_ff;
   logic                tot_valid_ff, tot_valid_in;
   logic                take;

   assign run_last = (count_ff == CNT_BITS'(SAMPLES_PER_AVERAGE - 1));
   // a closing item needs room in the totals register; others always go in
   assign in_ready = !run_last || !tot_valid_ff || tot_ready;
   assign take     = in_valid && in_ready;

   assign front_tot_in = front_sum_ff + SUM_BITS'(front_sample);
   assign left_tot_in  = left_sum_ff  + SUM_BITS'(left_sample);
   assign right_tot_in = right_sum_ff + SUM_BITS'(right_sample);

   always_comb begin
      count_in     = count_ff;
      front_sum_in = front_sum_ff;
      left_sum_in  = left_sum_ff;
      right_sum_in = right_sum_ff;
      tot_valid_in = tot_valid_ff && !tot_ready;
      if (take) begin
         if (run_last) begin
            count_in     = '0;
            front_sum_in = '0;
            left_sum_in  = '0;
            right_sum_in = '0;
            tot_valid_in = 1'b1;
         end else begin
            count_in     = count_ff + CNT_BITS'(1);
            front_sum_in = front_tot_in;
            left_sum_in  = left_tot_in;
            right_sum_in = right_tot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         front_sum_ff <= '0;
         left_sum_ff  <= '0;
         right_sum_ff <= '0;
         tot_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         front_sum_ff <= front_sum_in;
         left_sum_ff  <= left_sum_in;
         right_sum_ff <= right_sum_in;
         tot_valid_ff <= tot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && run_last) begin
         front_tot_ff <= front_tot_in;
         left_tot_ff  <= left_tot_in;
         right_tot_ff <= right_tot_in;
      end
   end

   assign tot_valid = tot_valid_ff;
   assign tot_front = front_tot_ff;
   assign tot_left  = left_tot_ff;
   assign tot_right = right_tot_ff;

endmodule

// File: design/wfpd_pd.sv
// PD front end: averages the run totals, forms the clamped error and the gain products.
// Depends on wfpd_pkg (cfg_type, error and term widths); two register stages.
module wfpd_pd #(
   parameter int SAMPLES_PER_AVERAGE = wfpd_pkg::SAMPLES_PER_AVERAGE_DEFAULT,
   parameter int SAMPLE_BITS         = wfpd_pkg::SAMPLE_BITS_DEFAULT,
   localparam int SUM_BITS           = SAMPLE_BITS + $clog2(SAMPLES_PER_AVERAGE)
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  wfpd_pkg::cfg_type                         cfg,
   input  logic                                      tot_valid,
   output logic                                      tot_ready,
   input  logic [SUM_BITS-1:0]                       tot_front,
   input  logic [SUM_BITS-1:0]                       tot_left,
   input  logic [SUM_BITS-1:0]                       tot_right,
   output logic                                      prd_valid,
   input  logic                                      prd_ready,
   output logic [SAMPLE_BITS-1:0]                    prd_front,
   output logic [SAMPLE_BITS-1:0]                    prd_left,
   output logic [SAMPLE_BITS-1:0]                    prd_right,
   output logic signed [wfpd_pkg::ERR_BITS-1:0]      prd_err,
   output logic signed [wfpd_pkg::KP_TERM_BITS-1:0]  prd_kp_term,
   output logic signed [wfpd_pkg::KD_TERM_BITS-1:0]  prd_kd_term
);

   localparam int DW = ((SAMPLE_BITS > wfpd_pkg::LEVEL_BITS) ?
                        SAMPLE_BITS : wfpd_pkg::LEVEL_BITS) + 1;

   // rounded-up reciprocal of the run length; exact for every total below 2**SUM_BITS
   localparam int DIV_SHIFT  = SUM_BITS + $clog2(SAMPLES_PER_AVERAGE);
   localparam int RECIP_BITS = DIV_SHIFT + 1;
   localparam int PW         = SUM_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(
      ((longint'(1) << DIV_SHIFT) + longint'(SAMPLES_PER_AVERAGE) - 1) /
      longint'(SAMPLES_PER_AVERAGE));

   logic [PW-1:0]          front_prod, left_prod, right_prod;
   logic [SAMPLE_BITS-1:0] front_avg_in, left_avg_in, right_avg_in;
   logic signed [DW-1:0]   diff;
   logic signed [wfpd_pkg::ERR_BITS-1:0]   err_in, last_err_ff;
   logic signed [wfpd_pkg::DELTA_BITS-1:0] delta_in;

   logic                   avg_valid_ff;
   logic [SAMPLE_BITS-1:0] avg_front_ff, avg_left_ff, avg_right_ff;
   logic signed [wfpd_pkg::ERR_BITS-1:0]   avg_err_ff;
   logic signed [wfpd_pkg::DELTA_BITS-1:0] avg_delta_ff;

   logic                   prd_valid_ff;
   logic [SAMPLE_BITS-1:0] prd_front_ff, prd_left_ff, prd_right_ff;
   logic signed [wfpd_pkg::ERR_BITS-1:0]     prd_err_ff;
   logic signed [wfpd_pkg::KP_TERM_BITS-1:0] kp_term_in, prd_kp_ff;
   logic signed [wfpd_pkg::KD_TERM_BITS-1:0] kd_term_in, prd_kd_ff;

   logic prd_open, avg_open, avg_load, prd_load;

   assign prd_open  = !prd_valid_ff || prd_ready;
   assign avg_open  = !avg_valid_ff || prd_open;
   assign tot_ready = avg_open;
   assign avg_load  = tot_valid && avg_open;
   assign prd_load  = avg_valid_ff && prd_open;

   // divide by the run length: multiply by the reciprocal, keep the bits above the shift
   assign front_prod = PW'(tot_front) * PW'(RECIP);
   assign left_prod  = PW'(tot_left)  * PW'(RECIP);
   assign right_prod = PW'(tot_right) * PW'(RECIP);

   assign front_avg_in = front_prod[DIV_SHIFT +: SAMPLE_BITS];
   assign left_avg_in  = left_prod[DIV_SHIFT +: SAMPLE_BITS];
   assign right_avg_in = right_prod[DIV_SHIFT +: SAMPLE_BITS];

   always_comb begin
      diff = $signed(DW'(left_avg_in)) - $signed(DW'(cfg.side_setpoint));
      if (diff > $signed(DW'(wfpd_pkg::ERR_LIMIT))) begin
         err_in = wfpd_pkg::ERR_BITS'(wfpd_pkg::ERR_LIMIT);
      end else if (diff < -$signed(DW'(wfpd_pkg::ERR_LIMIT))) begin
         err_in = -wfpd_pkg::ERR_BITS'(wfpd_pkg::ERR_LIMIT);
      end else begin
         err_in = wfpd_pkg::ERR_BITS'(diff);
      end
      delta_in = wfpd_pkg::DELTA_BITS'(err_in) - wfpd_pkg::DELTA_BITS'(last_err_ff);
   end

   assign kp_term_in = $signed({1'b0, cfg.kp_gain_q8}) * avg_err_ff;
   assign kd_term_in = $signed({1'b0, cfg.kd_gain_q8}) * avg_delta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_valid_ff <= 1'b0;
         prd_valid_ff <= 1'b0;
         last_err_ff  <= '0;
      end else begin
         if (avg_open) begin
            avg_valid_ff <= tot_valid;
         end
         if (prd_open) begin
            prd_valid_ff <= avg_valid_ff;
         end
         if (avg_load) begin
            last_err_ff <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (avg_load) begin
         avg_front_ff <= front_avg_in;
         avg_left_ff  <= left_avg_in;
         avg_right_ff <= right_avg_in;
         avg_err_ff   <= err_in;
         avg_delta_ff <= delta_in;
      end
      if (prd_load) begin
         prd_front_ff <= avg_front_ff;
         prd_left_ff  <= avg_left_ff;
         prd_right_ff <= avg_right_ff;
         prd_err_ff   <= avg_err_ff;
         prd_kp_ff    <= kp_term_in;
         prd_kd_ff    <= kd_term_in;
      end
   end

   assign prd_valid   = prd_valid_ff;
   assign prd_front   = prd_front_ff;
   assign prd_left    = prd_left_ff;
   assign prd_right   = prd_right_ff;
   assign prd_err     = prd_err_ff;
   assign prd_kp_term = prd_kp_ff;
   assign prd_kd_term = prd_kd_ff;

endmodule

// File: design/wfpd_drive.sv
// Drive stage: motor speeds from the PD terms, turn and veer decisions, result register.
// Depends on wfpd_pkg (cfg_type, widths, maneuver codes, veer speeds).
module wfpd_drive #(
   parameter int SAMPLE_BITS = wfpd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  wfpd_pkg::cfg_type                         cfg,
   input  logic                                      prd_valid,
   output logic                                      prd_ready,
   input  logic [SAMPLE_BITS-1:0]                    prd_front,
   input  logic [SAMPLE_BITS-1:0]                    prd_left,
   input  logic [SAMPLE_BITS-1:0]                    prd_right,
   input  logic signed [wfpd_pkg::ERR_BITS-1:0]      prd_err,
   input  logic signed [wfpd_pkg::KP_TERM_BITS-1:0]  prd_kp_term,
   input  logic signed [wfpd_pkg::KD_TERM_BITS-1:0]  prd_kd_term,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic [wfpd_pkg::MAN_BITS-1:0]             out_maneuver,
   output logic                                      out_fixed_veer,
   output logic signed [wfpd_pkg::DRIVE_BITS-1:0]    out_left_speed,
   output logic signed [wfpd_pkg::DRIVE_BITS-1:0]    out_right_speed,
   output logic signed [wfpd_pkg::ERR_BITS-1:0]      out_steer_error
);

   localparam int LW = (SAMPLE_BITS > wfpd_pkg::LEVEL_BITS) ?
                       SAMPLE_BITS : wfpd_pkg::LEVEL_BITS;
   localparam int QB = wfpd_pkg::Q_BITS;
   localparam int DB = wfpd_pkg::DRIVE_BITS;

   // divide by 256 toward zero, then clamp to the speed range
   function automatic logic signed [DB-1:0] sat_speed(input logic signed [QB-1:0] v);
      logic signed [QB-1:0] q;
      q = v >>> 8;
      if (v < 0 && v[7:0] != 8'd0) begin
         q = q + QB'(1);
      end
      if (q > $signed(QB'(wfpd_pkg::SPEED_LIMIT))) begin
         return DB'(wfpd_pkg::SPEED_LIMIT);
      end else if (q < -$signed(QB'(wfpd_pkg::SPEED_LIMIT))) begin
         return -DB'(wfpd_pkg::SPEED_LIMIT);
      end else begin
         return DB'(q);
      end
   endfunction

   logic signed [QB-1:0] corr, base_q, left_q, right_q;
   logic [LW-1:0] f, l, r;
   logic front_wall, left_wall, right_wall, left_open, right_open, veer_in;
   logic [wfpd_pkg::MAN_BITS-1:0] man_in;
   logic signed [DB-1:0] left_in, right_in;
   logic out_valid_ff, out_open, out_load;
   logic [wfpd_pkg::MAN_BITS-1:0] man_ff;
   logic veer_ff;
   logic signed [DB-1:0] left_ff, right_ff;
   logic signed [wfpd_pkg::ERR_BITS-1:0] err_ff;

   assign out_open  = !out_valid_ff || out_ready;
   assign prd_ready = out_open;
   assign out_load  = prd_valid && out_open;

   assign corr    = QB'(prd_kp_term) + QB'(prd_kd_term);
   assign base_q  = $signed(QB'({cfg.base_speed, 8'd0}));
   assign left_q  = base_q + corr;
   assign right_q = base_q - corr;

   assign f = LW'(prd_front);
   assign l = LW'(prd_left);
   assign r = LW'(prd_right);
   assign front_wall = f >= LW'(cfg.front_wall_level);
   assign left_wall  = l >= LW'(cfg.side_wall_level);
   assign right_wall = r >= LW'(cfg.side_wall_level);
   assign left_open  = l <= LW'(cfg.side_open_level);
   assign right_open = r <= LW'(cfg.side_open_level);
   assign veer_in    = right_wall && left_open;

   always_comb begin
      priority if (front_wall && left_wall && right_open) begin
         man_in = wfpd_pkg::MAN_TURN_RIGHT;
      end else if (front_wall && right_wall && left_open) begin
         man_in = wfpd_pkg::MAN_TURN_LEFT;
      end else begin
         man_in = wfpd_pkg::MAN_NONE;
      end
      if (veer_in) begin
         left_in  = DB'(wfpd_pkg::VEER_LEFT);
         right_in = DB'(wfpd_pkg::VEER_RIGHT);
      end else begin
         left_in  = sat_speed(left_q);
         right_in = sat_speed(right_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_open) begin
         out_valid_ff <= prd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         man_ff   <= man_in;
         veer_ff  <= veer_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         err_ff   <= prd_err;
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_maneuver    = man_ff;
   assign out_fixed_veer  = veer_ff;
   assign out_left_speed  = left_ff;
   assign out_right_speed = right_ff;
   assign out_steer_error = err_ff;

endmodule

// File: design/wall_follow_pd_steering.sv
// Top level of the wall-following PD steering block.
// Holds the config registers and chains wfpd_accum, wfpd_pd and wfpd_drive; uses wfpd_pkg.
//
// Usage:
//   req_* is a stream of distance triples (front, left, right), one item per beat.
//   Every SAMPLES_PER_AVERAGE items close a run: the run is averaged per channel,
//   the left average gives the steering error and the PD correction, and one
//   result item (maneuver, fixed veer flag, two motor speeds, error) leaves on rsp_*.
//   Items that do not close a run produce no result.
//   Throughput: one input item per cycle while no stall reaches the input. Path: the
//   edge that takes the closing item loads the totals; averages and error, gain
//   products and the result register follow in that order, and rsp_tvalid rises
//   when the result register loads.
//   Stall: each stage holds its item while the next one is full, so a waiting
//   result does not block the input; only a closing item waits, and only when
//   all stages ahead of it are full.
//   csr_*: one register write per cycle at csr_wr_en; write only while idle.
//   Reset (synchronous, active high) restores the register defaults, clears the
//   run sums, sample count and previous error, and empties the pipeline.
module wall_follow_pd_steering #(
   parameter int SAMPLES_PER_AVERAGE = wfpd_pkg::SAMPLES_PER_AVERAGE_DEFAULT,
   parameter int SAMPLE_BITS         = wfpd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // req_tdata fields from bit 0 up: front_sample, left_sample, right_sample, zero pad
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [8*((3*SAMPLE_BITS+7)/8)-1:0]       req_tdata,
   // rsp_tdata fields from bit 0 up: maneuver[1:0], fixed_veer[2], left_speed[10:3],
   // right_speed[18:11], steer_error[29:19], zero pad
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [wfpd_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   input  logic                                     csr_wr_en,
   input  logic [wfpd_pkg::CSR_ADDR_BITS-1:0]       csr_index,
   input  logic [wfpd_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   localparam int SUM_BITS = SAMPLE_BITS + $clog2(SAMPLES_PER_AVERAGE);

   wfpd_pkg::cfg_type cfg_ff;

   logic                run_last;
   logic                tot_valid, tot_ready;
   logic [SUM_BITS-1:0] tot_front, tot_left, tot_right;

   logic                   prd_valid, prd_ready;
   logic [SAMPLE_BITS-1:0] prd_front, prd_left, prd_right;
   logic signed [wfpd_pkg::ERR_BITS-1:0]     prd_err;
   logic signed [wfpd_pkg::KP_TERM_BITS-1:0] prd_kp_term;
   logic signed [wfpd_pkg::KD_TERM_BITS-1:0] prd_kd_term;

   logic [wfpd_pkg::MAN_BITS-1:0]          maneuver;
   logic                                   fixed_veer;
   logic signed [wfpd_pkg::DRIVE_BITS-1:0] left_speed, right_speed;
   logic signed [wfpd_pkg::ERR_BITS-1:0]   steer_error;

   // config registers: writes are masked to each register's width,
   // unlisted indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.side_setpoint    <= wfpd_pkg::SIDE_SETPOINT_RESET;
         cfg_ff.front_wall_level <= wfpd_pkg::FRONT_WALL_LEVEL_RESET;
         cfg_ff.side_wall_level  <= wfpd_pkg::SIDE_WALL_LEVEL_RESET;
         cfg_ff.side_open_level  <= wfpd_pkg::SIDE_OPEN_LEVEL_RESET;
         cfg_ff.base_speed       <= wfpd_pkg::BASE_SPEED_RESET;
         cfg_ff.kp_gain_q8       <= wfpd_pkg::KP_GAIN_RESET;
         cfg_ff.kd_gain_q8       <= wfpd_pkg::KD_GAIN_RESET;
      end else if (csr_wr_en) begin
         unique case (wfpd_pkg::csr_index_type'(csr_index))
            wfpd_pkg::CSR_SIDE_SETPOINT: begin
               cfg_ff.side_setpoint <= csr_wdata[wfpd_pkg::LEVEL_BITS-1:0];
            end
            wfpd_pkg::CSR_FRONT_WALL_LEVEL: begin
               cfg_ff.front_wall_level <= csr_wdata[wfpd_pkg::LEVEL_BITS-1:0];
            end
            wfpd_pkg::CSR_SIDE_WALL_LEVEL: begin
               cfg_ff.side_wall_level <= csr_wdata[wfpd_pkg::LEVEL_BITS-1:0];
            end
            wfpd_pkg::CSR_SIDE_OPEN_LEVEL: begin
               cfg_ff.side_open_level <= csr_wdata[wfpd_pkg::LEVEL_BITS-1:0];
            end
            wfpd_pkg::CSR_BASE_SPEED: begin
               cfg_ff.base_speed <= csr_wdata[wfpd_pkg::SPEED_BITS-1:0];
            end
            wfpd_pkg::CSR_KP_GAIN: begin
               cfg_ff.kp_gain_q8 <= csr_wdata[wfpd_pkg::GAIN_BITS-1:0];
            end
            wfpd_pkg::CSR_KD_GAIN: begin
               cfg_ff.kd_gain_q8 <= csr_wdata[wfpd_pkg::GAIN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // accumulate triples; a closing item moves the run totals into a register
   wfpd_accum #(
      .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
      .SAMPLE_BITS         (SAMPLE_BITS)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .front_sample (req_tdata[SAMPLE_BITS-1:0]),
      .left_sample  (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .right_sample (req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
      .run_last     (run_last),
      .tot_valid    (tot_valid),
      .tot_ready    (tot_ready),
      .tot_front    (tot_front),
      .tot_left     (tot_left),
      .tot_right    (tot_right)
   );

   // average, error against the setpoint, then the two gain products
   wfpd_pd #(
      .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
      .SAMPLE_BITS         (SAMPLE_BITS)
   ) u_pd (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .tot_valid   (tot_valid),
      .tot_ready   (tot_ready),
      .tot_front   (tot_front),
      .tot_left    (tot_left),
      .tot_right   (tot_right),
      .prd_valid   (prd_valid),
      .prd_ready   (prd_ready),
      .prd_front   (prd_front),
      .prd_left    (prd_left),
      .prd_right   (prd_right),
      .prd_err     (prd_err),
      .prd_kp_term (prd_kp_term),
      .prd_kd_term (prd_kd_term)
   );

   // speeds, turn and veer decisions, result register
   wfpd_drive #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_drive (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .prd_valid       (prd_valid),
      .prd_ready       (prd_ready),
      .prd_front       (prd_front),
      .prd_left        (prd_left),
      .prd_right       (prd_right),
      .prd_err         (prd_err),
      .prd_kp_term     (prd_kp_term),
      .prd_kd_term     (prd_kd_term),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_maneuver    (maneuver),
      .out_fixed_veer  (fixed_veer),
      .out_left_speed  (left_speed),
      .out_right_speed (right_speed),
      .out_steer_error (steer_error)
   );

   // pack the result fields, lowest first, zero pad on top
   assign rsp_tdata = {2'b00, steer_error, right_speed, left_speed, fixed_veer, maneuver};

`ifndef SYNTHESIS
   // only a closing item can ever be held off
   a_stall_only_on_close: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> run_last)
      else $error("input stalled on an item that does not close a run");

   // run totals stay put while the averaging stage is full
   a_totals_hold: assert property (@(posedge clock) disable iff (reset)
      tot_valid && !tot_ready |=> tot_valid)
      else $error("run totals dropped while stalled");

   // a new result always comes from a filled product stage
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(prd_valid))
      else $error("result appeared without a product stage item");
`endif

endmodule
